// ===== rtl/core/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg: shared constants and types for the 3x3 matrix inverse.
// Holds the fixed-point format, the wide arithmetic widths and the cofactor
// term table.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 4;
  localparam int NUM_ELEM   = 9;
  localparam int ADDR_W     = 4;

  // A product of two elements, a cofactor and the determinant.
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int COF_W  = PROD_W + 1;
  localparam int DET_W  = COF_W + DATA_WIDTH + 2;

  // Shared multiplier operand and product widths. A cofactor enters the
  // multiplier as a low unsigned word and a high signed word.
  localparam int MUL_W  = DATA_WIDTH + 1;
  localparam int MULP_W = 2 * MUL_W;

  // Scaled numerator magnitude and the quotient width kept by the divider.
  localparam int NUM_W  = COF_W + 2 * FRAC_BITS;
  localparam int QUO_W  = NUM_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [DET_W-1:0]      det_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Adjugate entry k is a[p]*a[q] - a[r]*a[s].
  function automatic logic [4*ADDR_W-1:0] adj_terms(input logic [ADDR_W-1:0] k);
    logic [4*ADDR_W-1:0] t;
    case (k)
      4'd0:    t = {4'd8, 4'd4, 4'd5, 4'd7};
      4'd1:    t = {4'd2, 4'd7, 4'd8, 4'd1};
      4'd2:    t = {4'd5, 4'd1, 4'd2, 4'd4};
      4'd3:    t = {4'd5, 4'd6, 4'd8, 4'd3};
      4'd4:    t = {4'd8, 4'd0, 4'd2, 4'd6};
      4'd5:    t = {4'd2, 4'd3, 4'd5, 4'd0};
      4'd6:    t = {4'd7, 4'd3, 4'd4, 4'd6};
      4'd7:    t = {4'd1, 4'd6, 4'd7, 4'd0};
      4'd8:    t = {4'd4, 4'd0, 4'd1, 4'd3};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/m3inv_div.sv =====
// ----------------------------------------------------------------------------
// m3inv_div: restoring divider, one quotient bit per cycle.
// Divides an unsigned numerator magnitude by the determinant magnitude.
// ----------------------------------------------------------------------------
module m3inv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [m3inv_pkg::NUM_W-1:0]   num,
  input  logic [m3inv_pkg::DET_W-1:0]   den,
  output logic [m3inv_pkg::QUO_W-1:0]   quo,
  output m3inv_pkg::div_stat_t          stat
);
  import m3inv_pkg::*;

  logic [NUM_W-1:0]  shreg;
  logic [DET_W:0]    rem;
  logic [DET_W-1:0]  dreg;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DET_W:0]    trial;
  logic [DET_W:0]    diff;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    trial = {rem[DET_W-1:0], shreg[NUM_W-1]};
    diff  = trial - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= STEP_W'(NUM_W);
        shreg <= num;
        dreg  <= den;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        shreg <= {shreg[NUM_W-2:0], 1'b0};
        if (!diff[DET_W]) begin
          rem <= diff;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse: inverse of a 3x3 signed fixed-point matrix by adjugate.
// Elements load one per beat; index eight starts the solve.
// ----------------------------------------------------------------------------
// After index eight the sequencer forms the cofactors, then the determinant;
// each result then goes through the shared bit-serial divider, which is
// skipped when the matrix is singular. The input stalls from the start beat
// until the last result beat is taken.
// Reset clears the sequencer; the element store is undefined until written.
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [m3inv_pkg::IDX_W-1:0]        element_index,
  input  logic signed [m3inv_pkg::DATA_WIDTH-1:0] element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [m3inv_pkg::IDX_W-1:0]        out_index,
  output logic signed [m3inv_pkg::DATA_WIDTH-1:0] out_value,
  output logic                               singular,
  output logic                               last_out
);
  import m3inv_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_P1, S_P2, S_COF, S_D1, S_D2, S_D3, S_DSUM, S_DIVGO, S_DIVWAIT, S_EMIT
  } state_t;

  state_t state;
  elem_t  store [NUM_ELEM];
  logic [ADDR_W-1:0] k;
  logic [1:0]        dstep;
  logic [ADDR_W-1:0] cidx;
  cof_t   cof [NUM_ELEM];
  det_t   det;
  det_t   dmag;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] prod;
  logic signed [MULP_W-1:0] dprod;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [MULP_W-1:0] mul_y;
  logic [4*ADDR_W-1:0] terms;
  logic                 div_start;
  logic [NUM_W-1:0]     div_num;
  logic [QUO_W-1:0]     quo;
  div_stat_t            dstat;
  logic                 neg;
  logic                 sing;
  cof_t                 cmag;
  logic [DATA_WIDTH-1:0] sat_val;

  localparam logic [QUO_W-1:0] MAXPOS = QUO_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic [QUO_W-1:0] MAXNEG = MAXPOS + 1'b1;

  assign terms = adj_terms(k);

  // Determinant term j pairs element j with cofactor 3*j.
  assign cidx = {1'b0, dstep, 1'b0} + {2'b00, dstep};

  // Shared multiplier operand selection. A determinant term is formed from
  // the low word of the cofactor first, then from its high word.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P1: begin
        mul_a = MUL_W'(store[terms[4*ADDR_W-1 -: ADDR_W]]);
        mul_b = MUL_W'(store[terms[3*ADDR_W-1 -: ADDR_W]]);
      end
      S_P2: begin
        mul_a = MUL_W'(store[terms[2*ADDR_W-1 -: ADDR_W]]);
        mul_b = MUL_W'(store[terms[ADDR_W-1 -: ADDR_W]]);
      end
      S_D1: begin
        mul_a = MUL_W'(store[{2'b00, dstep}]);
        mul_b = {1'b0, cof[cidx][DATA_WIDTH-1:0]};
      end
      S_D2: begin
        mul_a = MUL_W'(store[{2'b00, dstep}]);
        mul_b = cof[cidx][COF_W-1:DATA_WIDTH];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_y = MULP_W'(mul_a) * MULP_W'(mul_b);
  end

  // Divider numerator: scaled cofactor magnitude.
  always_comb begin
    cmag    = cof[k][COF_W-1] ? -cof[k] : cof[k];
    div_num = {cmag, {(2*FRAC_BITS){1'b0}}};
  end

  // Saturate and sign the quotient.
  always_comb begin
    if (!neg) begin
      sat_val = (quo > MAXPOS) ? MAXPOS[DATA_WIDTH-1:0] : quo[DATA_WIDTH-1:0];
    end else begin
      sat_val = (quo > MAXNEG) ? MAXNEG[DATA_WIDTH-1:0] : quo[DATA_WIDTH-1:0];
      sat_val = -sat_val;
    end
  end

  m3inv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dmag),
    .quo   (quo),
    .stat  (dstat)
  );

  assign in_stall = (state != S_LOAD);

  // Element store.
  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_valid && element_index <= IDX_W'(8)) begin
      store[element_index] <= element_value;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      k         <= '0;
      dstep     <= '0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (in_valid && element_index == IDX_W'(8)) begin
            state <= S_P1;
            k     <= '0;
          end
        end
        S_P1: begin
          prod1 <= mul_y[PROD_W-1:0];
          state <= S_P2;
        end
        S_P2: begin
          prod  <= mul_y[PROD_W-1:0];
          state <= S_COF;
        end
        S_COF: begin
          cof[k] <= COF_W'(prod1) - COF_W'(prod);
          if (k == ADDR_W'(NUM_ELEM-1)) begin
            state <= S_D1;
            dstep <= '0;
            det   <= '0;
          end else begin
            k     <= k + 1'b1;
            state <= S_P1;
          end
        end
        S_D1: begin
          dprod <= mul_y;
          state <= S_D2;
        end
        S_D2: begin
          det   <= det + DET_W'(dprod);
          dprod <= mul_y;
          state <= S_D3;
        end
        S_D3: begin
          det <= det + (DET_W'(dprod) <<< DATA_WIDTH);
          if (dstep == 2'd2) begin
            state <= S_DSUM;
          end else begin
            dstep <= dstep + 1'b1;
            state <= S_D1;
          end
        end
        S_DSUM: begin
          sing  <= (det == '0);
          dmag  <= det[DET_W-1] ? -det : det;
          k     <= '0;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          neg <= cof[k][COF_W-1] ^ det[DET_W-1];
          if (sing) begin
            out_valid <= 1'b1;
            out_index <= IDX_W'(k);
            out_value <= '0;
            singular  <= 1'b1;
            last_out  <= (k == ADDR_W'(NUM_ELEM-1));
            state     <= S_EMIT;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIVWAIT;
          end
        end
        S_DIVWAIT: begin
          if (dstat.done) begin
            out_valid <= 1'b1;
            out_index <= IDX_W'(k);
            out_value <= sat_val;
            singular  <= 1'b0;
            last_out  <= (k == ADDR_W'(NUM_ELEM-1));
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (k == ADDR_W'(NUM_ELEM-1)) begin
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_DIVGO;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== tb/matrix3_inverse_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_test: self-checking bench for the 3x3 fixed-point inverse.
// Element beats load the matrix and index eight starts a solve. An in-bench
// adjugate predictor builds the nine expected inverse beats for each solve
// not typed by hand; a monitor checks every output beat against them in order.
// ----------------------------------------------------------------------------
module matrix3_inverse_test;
  import m3inv_pkg::*;

  localparam int START_INDEX  = 8;
  localparam int RANDOM_ITEMS = 144;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 300;

  typedef logic signed [191:0] wide_t;

  // One expected inverse beat.
  typedef struct {
    logic [IDX_W-1:0] idx;
    elem_t            value;
    logic             sing;
    logic             last;
  } inv_beat_t;

  // One directed row; typed rows carry the inverse read off by hand.
  typedef struct {
    logic [IDX_W-1:0] idx;
    elem_t            value;
    bit               typed;
    elem_t            diag;
    elem_t            off;
    bit               sing;
  } row_t;

  // Adjugate entry k is a[p]*a[q] - a[r]*a[s].
  localparam int ADJ [9][4] = '{
    '{8, 4, 5, 7}, '{2, 7, 8, 1}, '{5, 1, 2, 4},
    '{5, 6, 8, 3}, '{8, 0, 2, 6}, '{2, 3, 5, 0},
    '{7, 3, 4, 6}, '{1, 6, 7, 0}, '{4, 0, 1, 3}
  };

  localparam elem_t ONE  = 32'sh0001_0000;
  localparam elem_t TINY = 32'sh0000_0001;
  localparam elem_t MAXV = 32'sh7fff_ffff;
  localparam elem_t MINV = 32'sh8000_0000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [IDX_W-1:0] element_index;
  elem_t            element_value;
  logic             out_valid;
  logic             out_stall;
  logic [IDX_W-1:0] out_index;
  elem_t            out_value;
  logic             singular;
  logic             last_out;

  elem_t     matrix_mirror [NUM_ELEM];
  inv_beat_t inverse_q [$];
  int        fail_count;
  int        send_idle_pct;
  int        stall_pct;
  bit        hold_req;

  matrix3_inverse uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_index (element_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_index     (out_index),
    .out_value     (out_value),
    .singular      (singular),
    .last_out      (last_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Adjugate over determinant, scaled back to Q16.16 and saturated.
  function automatic void predict_inverse();
    wide_t     a [NUM_ELEM];
    wide_t     cof [NUM_ELEM];
    wide_t     det, dmag, num, quo, maxpos;
    bit        neg, sing;
    inv_beat_t b;
    maxpos = wide_t'(MAXV);
    for (int k = 0; k < NUM_ELEM; k++) a[k] = matrix_mirror[k];
    for (int k = 0; k < NUM_ELEM; k++) begin
      cof[k] = a[ADJ[k][0]] * a[ADJ[k][1]] - a[ADJ[k][2]] * a[ADJ[k][3]];
    end
    det  = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    sing = (det == 0);
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < NUM_ELEM; k++) begin
      b.idx   = IDX_W'(k);
      b.sing  = sing;
      b.last  = (k == NUM_ELEM - 1);
      b.value = '0;
      if (!sing) begin
        num = cof[k] <<< (2 * FRAC_BITS);
        neg = (num < 0) != (det < 0);
        if (num < 0) num = -num;
        quo = num / dmag;
        if (!neg) begin
          if (quo > maxpos) quo = maxpos;
        end else begin
          if (quo > maxpos + 1) quo = maxpos + 1;
          quo = -quo;
        end
        b.value = quo[DATA_WIDTH-1:0];
      end
      inverse_q.push_back(b);
    end
  endfunction

  // Drives one element beat, starting and ending at a falling edge.
  task automatic send_element(input logic [IDX_W-1:0] idx, input elem_t value,
                              input bit typed, input elem_t diag,
                              input elem_t off, input bit sing);
    inv_beat_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    element_index = idx;
    element_value = value;
    do @(posedge clk); while (in_stall);
    if (idx <= START_INDEX) begin
      matrix_mirror[idx] = value;
      if (idx == START_INDEX) begin
        if (typed) begin
          for (int k = 0; k < NUM_ELEM; k++) begin
            b.idx   = IDX_W'(k);
            b.value = (k % 4 == 0) ? diag : off;
            b.sing  = sing;
            b.last  = (k == NUM_ELEM - 1);
            inverse_q.push_back(b);
          end
        end else begin
          predict_inverse();
        end
      end
    end
    @(negedge clk);
  endtask

  function automatic elem_t rand_element();
    elem_t v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = elem_t'($urandom_range(32'h40000)) - 32'sh20000;
      5, 6:          v = $urandom;
      7: begin
        case ($urandom_range(3))
          0:       v = MAXV;
          1:       v = MINV;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      default:       v = (elem_t'($urandom_range(8)) - 4) * ONE;
    endcase
    return v;
  endfunction

  // Random beat with an occasional ignored index in front of it.
  task automatic send_random(input logic [IDX_W-1:0] idx, input elem_t value);
    if ($urandom_range(9) == 0) begin
      send_element(IDX_W'($urandom_range(15, 9)), $urandom, 0, '0, '0, 0);
    end
    send_element(idx, value, 0, '0, '0, 0);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Checks each accepted output beat against the oldest expectation.
  always @(posedge clk) begin
    inv_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected beat idx %0d value %h", $time, out_index, out_value);
        fail_count++;
      end else begin
        e = inverse_q.pop_front();
        if (out_index !== e.idx || out_value !== e.value ||
            singular !== e.sing || last_out !== e.last) begin
          $display("%0t: expected idx %0d value %h sing %b last %b", $time,
                   e.idx, e.value, e.sing, e.last);
          $display("%0t: actual   idx %0d value %h sing %b last %b", $time,
                   out_index, out_value, singular, last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    row_t rows [$];
    int   sent;
    int   perm [8];
    int   j, t, kind, n;
    elem_t m [NUM_ELEM];

    rst           = 1'b1;
    in_valid      = 1'b0;
    element_index = '0;
    element_value = '0;
    fail_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    for (int k = 0; k < NUM_ELEM; k++) matrix_mirror[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: zero matrix, identity, tiny and negative tiny diagonals
    // that saturate, ignored indices, and a repeated start with extremes.
    for (int k = 0; k < NUM_ELEM - 1; k++) begin
      rows.push_back('{IDX_W'(k), '0, 0, '0, '0, 0});
    end
    rows.push_back('{8, '0, 1, '0, '0, 1});
    rows.push_back('{0, ONE, 0, '0, '0, 0});
    rows.push_back('{4, ONE, 0, '0, '0, 0});
    rows.push_back('{8, ONE, 1, ONE, '0, 0});
    rows.push_back('{0, TINY, 0, '0, '0, 0});
    rows.push_back('{4, TINY, 0, '0, '0, 0});
    rows.push_back('{8, TINY, 1, MAXV, '0, 0});
    rows.push_back('{0, -TINY, 0, '0, '0, 0});
    rows.push_back('{4, -TINY, 0, '0, '0, 0});
    rows.push_back('{8, -TINY, 1, MINV, '0, 0});
    rows.push_back('{9, MAXV, 0, '0, '0, 0});
    rows.push_back('{15, MINV, 0, '0, '0, 0});
    rows.push_back('{1, MINV, 0, '0, '0, 0});
    rows.push_back('{3, MAXV, 0, '0, '0, 0});
    rows.push_back('{8, MAXV, 0, '0, '0, 0});
    rows.push_back('{8, MINV, 0, '0, '0, 0});
    foreach (rows[i]) begin
      send_element(rows[i].idx, rows[i].value, rows[i].typed, rows[i].diag,
                   rows[i].off, rows[i].sing);
    end

    // Sender pauses until every inverse beat has drained.
    in_valid = 1'b0;
    wait (inverse_q.size() == 0);
    @(negedge clk);

    // Random matrices; the output side holds off early to back up the block.
    hold_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 4 / RANDOM_ITEMS)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 79; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      kind = $urandom_range(9);
      if (kind < 6) begin
        // Full matrix, first eight elements in shuffled order.
        for (int k = 0; k < 8; k++) perm[k] = k;
        for (int k = 7; k > 0; k--) begin
          j = $urandom_range(k);
          t = perm[k]; perm[k] = perm[j]; perm[j] = t;
        end
        for (int k = 0; k < 8; k++) send_random(IDX_W'(perm[k]), rand_element());
        send_random(IDX_W'(START_INDEX), rand_element());
        sent += 9;
      end else if (kind < 8) begin
        // Partial update reusing the stored entries.
        n = $urandom_range(3);
        for (int k = 0; k < n; k++) begin
          send_random(IDX_W'($urandom_range(7)), rand_element());
        end
        send_random(IDX_W'(START_INDEX), rand_element());
        sent += n + 1;
      end else begin
        // Singular: third row repeats the first.
        for (int k = 0; k < 6; k++) m[k] = rand_element();
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
        for (int k = 0; k < NUM_ELEM; k++) send_random(IDX_W'(k), m[k]);
        sent += 9;
      end
    end
    in_valid = 1'b0;

    wait (inverse_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
